// ===== design/dtpc_pkg.sv =====
`default_nettype none

package dtpc_pkg;

  localparam int unsigned ACC_W   = 14;
  localparam int unsigned ACC_N_W = 18;
  localparam int unsigned NUM_ACC = 8;
  localparam int unsigned ACC_MAX = 9999;

  localparam int unsigned YEAR_MIN   = 1000;
  localparam int unsigned MONTH_MAX  = 12;
  localparam int unsigned HOUR_MAX   = 23;
  localparam int unsigned MINUTE_MAX = 59;

  localparam int unsigned MOD25_SAT   = 9999 % 25;
  localparam int unsigned MOD25_RECIP = 41;
  localparam int unsigned MOD25_SHIFT = 10;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned RESULT_DEPTH = 2;

  localparam logic [7:0] CH_DAY    = 8'h44;
  localparam logic [7:0] CH_MONTH  = 8'h4D;
  localparam logic [7:0] CH_YEAR   = 8'h59;
  localparam logic [7:0] CH_HOUR   = 8'h68;
  localparam logic [7:0] CH_MINUTE = 8'h6D;
  localparam logic [7:0] CH_SECOND = 8'h73;
  localparam logic [7:0] CH_MSEC   = 8'h63;
  localparam logic [7:0] CH_OHOUR  = 8'h4F;
  localparam logic [7:0] CH_OMIN   = 8'h6F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    FLD_DAY    = 4'd0,
    FLD_MONTH  = 4'd1,
    FLD_YEAR   = 4'd2,
    FLD_HOUR   = 4'd3,
    FLD_MINUTE = 4'd4,
    FLD_SECOND = 4'd5,
    FLD_OHOUR  = 4'd6,
    FLD_OMIN   = 4'd7,
    FLD_NONE   = 4'd8
  } field_e;

  typedef struct packed {
    field_e     field;
    logic       acc_en;
    logic [3:0] digit;
    logic       mismatch;
    logic       last;
    logic       ldiff;
  } item_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    unique case (month)
      4'd2:                    days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:                 days = 5'd31;
    endcase
    return days;
  endfunction

  // remainder by 25 of a value below 250
  function automatic logic [4:0] mod25(input logic [7:0] v);
    logic [13:0] prod;
    logic [3:0]  quo;
    logic [7:0]  rem;
    prod = 14'(v) * 14'(MOD25_RECIP);
    quo  = prod[13:MOD25_SHIFT];
    rem  = v - 8'(quo * 8'd25);
    return rem[4:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/dtpc_fifo.sv =====
`default_nettype none

module dtpc_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/dtpc_front.sv =====
`default_nettype none

module dtpc_front
  import dtpc_pkg::*;
(
  input  wire logic [7:0] pattern_char_i,
  input  wire logic [7:0] text_char_i,
  input  wire logic       last_pair_i,
  input  wire logic       lengths_differ_i,
  output item_t           item_o
);

  logic   is_digit, digit_pos, literal_bad;
  field_e field;

  assign is_digit = (text_char_i >= CH_ZERO) && (text_char_i <= CH_NINE);

  always_comb begin
    field       = FLD_NONE;
    digit_pos   = 1'b1;
    literal_bad = 1'b0;
    unique case (pattern_char_i)
      CH_DAY:    field = FLD_DAY;
      CH_MONTH:  field = FLD_MONTH;
      CH_YEAR:   field = FLD_YEAR;
      CH_HOUR:   field = FLD_HOUR;
      CH_MINUTE: field = FLD_MINUTE;
      CH_SECOND: field = FLD_SECOND;
      CH_MSEC:   field = FLD_NONE;
      CH_OHOUR:  field = FLD_OHOUR;
      CH_OMIN:   field = FLD_OMIN;
      CH_PLUS: begin
        digit_pos   = 1'b0;
        literal_bad = (text_char_i != CH_MINUS) && (text_char_i != CH_PLUS);
      end
      default: begin
        digit_pos   = 1'b0;
        literal_bad = (text_char_i != pattern_char_i);
      end
    endcase
  end

  always_comb begin
    item_o.field    = field;
    item_o.acc_en   = digit_pos && is_digit && (field != FLD_NONE);
    item_o.digit    = is_digit ? text_char_i[3:0] : 4'd0;
    item_o.mismatch = digit_pos ? !is_digit : literal_bad;
    item_o.last     = last_pair_i;
    item_o.ldiff    = lengths_differ_i;
  end

endmodule

`default_nettype wire

// ===== design/dtpc_back.sv =====
`default_nettype none

module dtpc_back
  import dtpc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  item_t      item_i,
  input  wire logic  item_avail_i,
  output logic       item_pop_o,
  input  wire logic  res_full_i,
  output logic       res_push_o,
  output logic       res_o
);

  logic [ACC_W-1:0] acc_q [NUM_ACC];
  logic [ACC_W-1:0] acc_upd [NUM_ACC];
  logic [ACC_W-1:0] acc_d [NUM_ACC];
  logic [4:0]       ymod_q, ymod_d, ymod_upd;
  logic             saw_day_q, saw_day_d, saw_day_upd;
  logic             saw_month_q, saw_month_d, saw_month_upd;
  logic             saw_year_q, saw_year_d, saw_year_upd;
  logic             mis_q, mis_d, mis_upd;

  logic [ACC_W-1:0] chk_acc_q [NUM_ACC];
  logic [4:0]       chk_ymod_q;
  logic             chk_saw_day_q, chk_saw_month_q, chk_saw_year_q, chk_bad_q;
  logic             chk_valid_q, chk_valid_d;

  logic [2:0]         idx;
  logic [ACC_W-1:0]   sel;
  logic [ACC_N_W-1:0] prod;
  logic               sat, stall, take_last;
  logic [ACC_W-1:0]   acc_new;
  logic [4:0]         ymod_new;

  assign stall      = chk_valid_q && res_full_i;
  assign item_pop_o = item_avail_i && !stall;
  assign take_last  = item_pop_o && item_i.last;
  assign res_push_o = chk_valid_q;

  assign idx  = item_i.field[2:0];
  assign sel  = acc_q[idx];
  assign prod = ACC_N_W'({sel, 3'b000}) + ACC_N_W'({sel, 1'b0}) + ACC_N_W'(item_i.digit);
  assign sat  = (prod > ACC_N_W'(ACC_MAX));
  assign acc_new  = sat ? ACC_W'(ACC_MAX) : prod[ACC_W-1:0];
  assign ymod_new = sat ? 5'(MOD25_SAT)
                        : mod25(8'({ymod_q, 3'b000}) + 8'({ymod_q, 1'b0}) + 8'(item_i.digit));

  always_comb begin
    acc_upd       = acc_q;
    ymod_upd      = ymod_q;
    saw_day_upd   = saw_day_q;
    saw_month_upd = saw_month_q;
    saw_year_upd  = saw_year_q;
    mis_upd       = mis_q;
    if (item_pop_o) begin
      if (item_i.acc_en) begin
        acc_upd[idx] = acc_new;
        if (item_i.field == FLD_YEAR) begin
          ymod_upd = ymod_new;
        end
      end
      saw_day_upd   = saw_day_q || (item_i.field == FLD_DAY);
      saw_month_upd = saw_month_q || (item_i.field == FLD_MONTH);
      saw_year_upd  = saw_year_q || (item_i.field == FLD_YEAR);
      mis_upd       = mis_q || item_i.mismatch;
    end
  end

  always_comb begin
    acc_d       = acc_upd;
    ymod_d      = ymod_upd;
    saw_day_d   = saw_day_upd;
    saw_month_d = saw_month_upd;
    saw_year_d  = saw_year_upd;
    mis_d       = mis_upd;
    if (take_last) begin
      for (int i = 0; i < NUM_ACC; i++) begin
        acc_d[i] = '0;
      end
      ymod_d      = '0;
      saw_day_d   = 1'b0;
      saw_month_d = 1'b0;
      saw_year_d  = 1'b0;
      mis_d       = 1'b0;
    end
  end

  always_comb begin
    chk_valid_d = chk_valid_q;
    if (take_last) begin
      chk_valid_d = 1'b1;
    end else if (chk_valid_q && !res_full_i) begin
      chk_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ACC; i++) begin
        acc_q[i] <= '0;
      end
      ymod_q      <= '0;
      saw_day_q   <= 1'b0;
      saw_month_q <= 1'b0;
      saw_year_q  <= 1'b0;
      mis_q       <= 1'b0;
      chk_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      ymod_q      <= ymod_d;
      saw_day_q   <= saw_day_d;
      saw_month_q <= saw_month_d;
      saw_year_q  <= saw_year_d;
      mis_q       <= mis_d;
      chk_valid_q <= chk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_last) begin
      chk_acc_q       <= acc_upd;
      chk_ymod_q      <= ymod_upd;
      chk_saw_day_q   <= saw_day_upd;
      chk_saw_month_q <= saw_month_upd;
      chk_saw_year_q  <= saw_year_upd;
      chk_bad_q       <= mis_upd || item_i.ldiff;
    end
  end

  logic [ACC_W-1:0] year, month, day;
  logic             month_ok, div4, div16, div25, leap;
  logic [4:0]       lim;

  assign year     = chk_acc_q[FLD_YEAR[2:0]];
  assign month    = chk_acc_q[FLD_MONTH[2:0]];
  assign day      = chk_acc_q[FLD_DAY[2:0]];
  assign month_ok = (month != '0) && (month <= ACC_W'(MONTH_MAX));
  assign div4     = (year[1:0] == 2'b00);
  assign div16    = (year[3:0] == 4'b0000);
  assign div25    = (chk_ymod_q == '0);
  assign leap     = (div4 && !div25) || (div16 && div25);
  assign lim      = month_days(month[3:0], leap);

  always_comb begin
    res_o = !chk_bad_q;
    if (chk_saw_year_q && (year < ACC_W'(YEAR_MIN))) begin
      res_o = 1'b0;
    end
    if (chk_saw_month_q && !month_ok) begin
      res_o = 1'b0;
    end
    if (chk_saw_day_q && chk_saw_month_q && ((day == '0) || (day > ACC_W'(lim)))) begin
      res_o = 1'b0;
    end
    if ((chk_acc_q[FLD_HOUR[2:0]] > ACC_W'(HOUR_MAX)) ||
        (chk_acc_q[FLD_MINUTE[2:0]] > ACC_W'(MINUTE_MAX)) ||
        (chk_acc_q[FLD_SECOND[2:0]] > ACC_W'(MINUTE_MAX)) ||
        (chk_acc_q[FLD_OHOUR[2:0]] > ACC_W'(HOUR_MAX)) ||
        (chk_acc_q[FLD_OMIN[2:0]] > ACC_W'(MINUTE_MAX))) begin
      res_o = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/date_time_pattern_checker_top.sv =====
`default_nettype none

// Date/time pattern checker: push one pattern/text character pair per cycle
// while full is low; each string ends with a pair marked last_pair_i, and only
// that pair yields a result (valid_res_o), registered in a check stage and then
// written into a RESULT_DEPTH-entry result queue. The block sustains one
// transaction per clock while the result queue has room: the front classifies a
// pair in the cycle it arrives, a QUEUE_DEPTH-entry queue holds it, and the back
// updates one decimal accumulator per cycle unless stalled and checks the
// finished fields in that check stage. Strings may follow each other with no gap.
module date_time_pattern_checker_top
  import dtpc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P  = QUEUE_DEPTH,
  parameter int unsigned RESULT_DEPTH_P = RESULT_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] pattern_char_i,
  input  wire logic [7:0] text_char_i,
  input  wire logic       last_pair_i,
  input  wire logic       lengths_differ_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            valid_res_o
);

  item_t front_item, back_item;
  logic  mid_empty, back_pop, res_full, res_push, res_bit;

  dtpc_front u_front (
    .pattern_char_i   (pattern_char_i),
    .text_char_i      (text_char_i),
    .last_pair_i      (last_pair_i),
    .lengths_differ_i (lengths_differ_i),
    .item_o           (front_item)
  );

  dtpc_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (back_pop),
    .data_o  (back_item),
    .empty_o (mid_empty)
  );

  dtpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_avail_i (!mid_empty),
    .item_pop_o   (back_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_bit)
  );

  dtpc_fifo #(
    .WIDTH (1),
    .DEPTH (RESULT_DEPTH_P)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_bit),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (valid_res_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// ===== sim/date_time_pattern_checker_top_tb.sv =====
module date_time_pattern_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtpc_pkg::*;

  localparam int ITEMS          = 450;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam logic [7:0] LETTERS [10] = '{CH_DAY, CH_MONTH, CH_YEAR, CH_HOUR, CH_MINUTE,
                                          CH_SECOND, CH_MSEC, CH_OHOUR, CH_OMIN, CH_PLUS};

  typedef struct packed {
    logic [7:0] pc;
    logic [7:0] tc;
    logic       last;
    logic       ldiff;
    logic       typed;
    logic       verdict;
  } pair_row_t;

  localparam pair_row_t DIRECTED [26] = '{
    '{8'h00,     8'h00,    1'b1, 1'b0, 1'b1, 1'b1},
    '{8'hFF,     8'hFF,    1'b1, 1'b1, 1'b1, 1'b0},
    '{8'hFF,     8'h00,    1'b1, 1'b0, 1'b1, 1'b0},
    '{CH_DAY,    "2",      1'b0, 1'b1, 1'b0, 1'b0},
    '{CH_DAY,    "9",      1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_MINUS,  CH_MINUS, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_MONTH,  CH_ZERO,  1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_MONTH,  "2",      1'b1, 1'b0, 1'b0, 1'b0},
    '{CH_YEAR,   CH_NINE,  1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_YEAR,   CH_NINE,  1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_YEAR,   CH_NINE,  1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_YEAR,   CH_NINE,  1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_YEAR,   CH_NINE,  1'b1, 1'b0, 1'b0, 1'b0},
    '{CH_HOUR,   "2",      1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_HOUR,   "3",      1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_MINUTE, "5",      1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_SECOND, "9",      1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_MSEC,   "7",      1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_PLUS,   CH_MINUS, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_OHOUR,  "2",      1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_OMIN,   "9",      1'b1, 1'b0, 1'b0, 1'b0},
    '{CH_MSEC,   "/",      1'b1, 1'b0, 1'b1, 1'b0},
    '{CH_PLUS,   CH_PLUS,  1'b1, 1'b0, 1'b1, 1'b1},
    '{CH_MONTH,  CH_ZERO,  1'b1, 1'b0, 1'b1, 1'b0},
    '{CH_HOUR,   CH_NINE,  1'b0, 1'b0, 1'b0, 1'b0},
    '{CH_HOUR,   ":",      1'b1, 1'b0, 1'b1, 1'b0}
  };

  typedef struct packed {
    logic [ACC_W-1:0] day, month, year, hour, minute, second, ohour, omin;
    logic             saw_day, saw_month, saw_year, bad;
  } stamp_t;

  logic       clk_i;
  logic       rst_ni           = 1'b0;
  logic       push             = 1'b0;
  logic       full;
  logic [7:0] pattern_char_i   = '0;
  logic [7:0] text_char_i      = '0;
  logic       last_pair_i      = 1'b0;
  logic       lengths_differ_i = 1'b0;
  logic       empty;
  logic       pop              = 1'b0;
  logic       valid_res_o;

  stamp_t     stamp = '0;
  logic       pending_valid [$];
  logic [7:0] pat_q [$];
  logic [7:0] txt_q [$];
  int         fail_count   = 0;
  int         results_seen = 0;
  int         stall_cycles = 0;
  int         send_calm    = 0;
  int         recv_calm    = 0;
  logic       hold_done    = 1'b0;

  date_time_pattern_checker_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .pattern_char_i   (pattern_char_i),
    .text_char_i      (text_char_i),
    .last_pair_i      (last_pair_i),
    .lengths_differ_i (lengths_differ_i),
    .empty            (empty),
    .pop              (pop),
    .valid_res_o      (valid_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ACC_W-1:0] shift_in_digit(input logic [ACC_W-1:0] acc,
                                                       input logic [3:0] d);
    int unsigned n;
    n = int'(acc) * 10 + int'(d);
    return (n > ACC_MAX) ? ACC_W'(ACC_MAX) : ACC_W'(n);
  endfunction

  function automatic logic fields_in_range();
    int unsigned lim;
    logic        leap;
    if (stamp.saw_year && stamp.year < YEAR_MIN) return 1'b0;
    if (stamp.saw_month && (stamp.month == 0 || stamp.month > MONTH_MAX)) return 1'b0;
    if (stamp.saw_day && stamp.saw_month) begin
      leap = (stamp.year % 4 == 0 && stamp.year % 100 != 0) || stamp.year % 400 == 0;
      lim = DAYS_PER_MONTH[stamp.month - 1];
      if (stamp.month == 2 && leap) lim = 29;
      if (stamp.day == 0 || stamp.day > lim) return 1'b0;
    end
    if (stamp.hour > HOUR_MAX || stamp.minute > MINUTE_MAX || stamp.second > MINUTE_MAX)
      return 1'b0;
    if (stamp.ohour > HOUR_MAX || stamp.omin > MINUTE_MAX) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic predict_pair(input logic [7:0] pc, tc, input logic last, ldiff,
                                        output logic verdict);
    logic       digit;
    logic       numeric;
    logic [3:0] dv;
    digit   = tc >= CH_ZERO && tc <= CH_NINE;
    dv      = 4'(tc - CH_ZERO);
    numeric = 1'b1;
    verdict = 1'b0;
    case (pc)
      CH_DAY: begin
        stamp.saw_day = 1'b1;
        if (digit) stamp.day = shift_in_digit(stamp.day, dv);
      end
      CH_MONTH: begin
        stamp.saw_month = 1'b1;
        if (digit) stamp.month = shift_in_digit(stamp.month, dv);
      end
      CH_YEAR: begin
        stamp.saw_year = 1'b1;
        if (digit) stamp.year = shift_in_digit(stamp.year, dv);
      end
      CH_HOUR:   if (digit) stamp.hour = shift_in_digit(stamp.hour, dv);
      CH_MINUTE: if (digit) stamp.minute = shift_in_digit(stamp.minute, dv);
      CH_SECOND: if (digit) stamp.second = shift_in_digit(stamp.second, dv);
      CH_OHOUR:  if (digit) stamp.ohour = shift_in_digit(stamp.ohour, dv);
      CH_OMIN:   if (digit) stamp.omin = shift_in_digit(stamp.omin, dv);
      CH_MSEC:   ;
      CH_PLUS: begin
        numeric = 1'b0;
        if (tc != CH_MINUS && tc != CH_PLUS) stamp.bad = 1'b1;
      end
      default: begin
        numeric = 1'b0;
        if (tc != pc) stamp.bad = 1'b1;
      end
    endcase
    if (numeric && !digit) stamp.bad = 1'b1;
    if (!last) return 1'b0;
    verdict = !stamp.bad && !ldiff && fields_in_range();
    stamp = '0;
    return 1'b1;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic void put_lit(input logic [7:0] c);
    pat_q = {pat_q, c};
    txt_q = {txt_q, c};
  endfunction

  function automatic void put_num(input logic [7:0] letter, input int ndig,
                                  input int unsigned value);
    int unsigned scale;
    logic [7:0]  ch;
    scale = 1;
    repeat (ndig - 1) scale *= 10;
    for (int i = 0; i < ndig; i++) begin
      ch    = CH_ZERO + 8'((value / scale) % 10);
      pat_q = {pat_q, letter};
      txt_q = {txt_q, ch};
      scale /= 10;
    end
  endfunction

  function automatic int pick_width(input int usual);
    return ($urandom_range(0, 9) < 7) ? usual : $urandom_range(1, usual + 2);
  endfunction

  function automatic int unsigned near(input int unsigned lo, hi, bad_hi);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(hi + 1, bad_hi)
                                       : $urandom_range(lo, hi);
  endfunction

  function automatic int unsigned rand_year();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(1000, 2400);
      1:       return 100 * $urandom_range(0, 24);
      2:       return 4 * $urandom_range(0, 2499);
      3:       return $urandom_range(10000, 999999);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  function automatic int unsigned rand_day();
    case ($urandom_range(0, 4))
      0, 1:    return $urandom_range(1, 28);
      2:       return $urandom_range(28, 31);
      3:       return $urandom_range(0, 39);
      default: return $urandom_range(1, 31);
    endcase
  endfunction

  function automatic void build_string();
    int         n;
    logic       dated, timed, year_first, with_year, with_day;
    logic [7:0] pc, tc;
    pat_q.delete();
    txt_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        pc    = ($urandom_range(0, 3) == 0) ? LETTERS[$urandom_range(0, 9)]
                                            : 8'($urandom_range(0, 255));
        tc    = 8'($urandom_range(0, 255));
        pat_q = {pat_q, pc};
        txt_q = {txt_q, tc};
      end
      return;
    end
    dated      = $urandom_range(0, 3) != 0;
    timed      = !dated || $urandom_range(0, 2) != 0;
    year_first = $urandom_range(0, 1);
    with_year  = $urandom_range(0, 5) != 0;
    with_day   = $urandom_range(0, 5) != 0;
    if (dated) begin
      if (year_first && with_year) begin
        put_num(CH_YEAR, pick_width(4), rand_year());
        put_lit(CH_MINUS);
      end
      if (!year_first && with_day) begin
        put_num(CH_DAY, pick_width(2), rand_day());
        put_lit(".");
      end
      put_num(CH_MONTH, pick_width(2), near(1, 12, 19));
      if (year_first && with_day) begin
        put_lit(CH_MINUS);
        put_num(CH_DAY, pick_width(2), rand_day());
      end
      if (!year_first && with_year) begin
        put_lit(".");
        put_num(CH_YEAR, pick_width(4), rand_year());
      end
    end
    if (dated && timed) put_lit("T");
    if (timed) begin
      put_num(CH_HOUR, pick_width(2), near(0, 23, 99));
      put_lit(":");
      put_num(CH_MINUTE, pick_width(2), near(0, 59, 99));
      if ($urandom_range(0, 3) != 0) begin
        put_lit(":");
        put_num(CH_SECOND, pick_width(2), near(0, 59, 99));
      end
      if ($urandom_range(0, 3) == 0) begin
        put_lit(".");
        put_num(CH_MSEC, $urandom_range(1, 3), $urandom_range(0, 999));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      tc    = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      pat_q = {pat_q, CH_PLUS};
      txt_q = {txt_q, tc};
      put_num(CH_OHOUR, pick_width(2), near(0, 23, 99));
      put_lit(":");
      put_num(CH_OMIN, pick_width(2), near(0, 59, 99));
    end
    if ($urandom_range(0, 3) == 0)
      txt_q[$urandom_range(0, txt_q.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pair(input logic [7:0] pc, tc, input logic last, ldiff, typed, verdict);
    int   gap;
    logic predicted;
    logic expected;
    gap = pick_gap(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push             <= 1'b1;
    pattern_char_i   <= pc;
    text_char_i      <= tc;
    last_pair_i      <= last;
    lengths_differ_i <= ldiff;
    do @(posedge clk_i); while (full);
    if (predict_pair(pc, tc, last, ldiff, predicted)) begin
      expected      = typed ? verdict : predicted;
      pending_valid = {pending_valid, expected};
    end
  endtask

  initial begin : stimulus
    int   sent;
    logic last_flag;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (DIRECTED[i])
      send_pair(DIRECTED[i].pc, DIRECTED[i].tc, DIRECTED[i].last, DIRECTED[i].ldiff,
                DIRECTED[i].typed, DIRECTED[i].verdict);
    sent = $size(DIRECTED);
    while (sent < ITEMS) begin
      build_string();
      foreach (pat_q[i]) begin
        last_flag = (i == pat_q.size() - 1);
        send_pair(pat_q[i], txt_q[i], last_flag,
                  last_flag ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 7) == 0),
                  1'b0, 1'b0);
      end
      sent += pat_q.size();
    end
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_valid.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : result_drain
    int idle_left;
    int gap;
    idle_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        pop       <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else begin
        gap       = pick_gap(recv_calm);
        pop       <= (gap == 0);
        idle_left = (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      results_seen <= results_seen + 1;
      if (pending_valid.size() == 0) begin
        $error("unexpected transaction: valid_res = %0b", valid_res_o);
        fail_count++;
      end else if (valid_res_o !== pending_valid[0]) begin
        $error("valid_res mismatch: expected %0b, actual %0b", pending_valid[0], valid_res_o);
        fail_count++;
        void'(pending_valid.pop_front());
      end else begin
        void'(pending_valid.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
